// ===== hw/rtl/ftcs_pkg.sv =====
// Shared types and constants for the FTCS heat equation stepper.
// Used by ftcs_point_unit and heat_equation_ftcs_stepper_unit; no dependencies.
package ftcs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int POS_W      = 6;
  localparam int VAL_W      = 32;
  localparam int LAMBDA_W   = 16;
  localparam int LAST_W     = 6;
  localparam int LAP_W      = VAL_W + 3;
  localparam int PROD_W     = LAP_W + LAMBDA_W + 1;
  localparam int FRAC_W     = 16;
  localparam int SUM_W      = PROD_W - FRAC_W + 1;

  localparam logic [LAMBDA_W-1:0] LAMBDA_MAX = 16'h8000;
  localparam logic [LAMBDA_W-1:0] LAMBDA_RST = 16'h4000;
  localparam logic [LAST_W-1:0]   LAST_RST   = 6'd63;
  localparam logic [LAST_W-1:0]   LAST_MIN   = 6'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic CFG_LAMBDA = 1'b0;
  localparam logic CFG_LAST   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD0,
    ST_LAP,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic lap_en;
    logic mul_en;
  } pu_ctrl_t;

endpackage

// ===== hw/rtl/ftcs_point_unit.sv =====
// Shared stencil unit: Laplacian, gain multiply, rounding and saturating add.
// Depends on ftcs_pkg; stepped by the sequencer in the top level.
module ftcs_point_unit import ftcs_pkg::*; (
  input  logic                       clk,
  input  pu_ctrl_t                   ctrl,
  input  logic signed [VAL_W-1:0]    left_val,
  input  logic signed [VAL_W-1:0]    center_val,
  input  logic signed [VAL_W-1:0]    right_val,
  input  logic        [LAMBDA_W-1:0] lambda,
  output logic signed [VAL_W-1:0]    result
);

  logic signed [LAP_W-1:0]  lap_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [SUM_W-1:0]  delta;
  logic signed [SUM_W-1:0]  sum;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sh8000_0000);

  always_ff @(posedge clk) begin
    if (ctrl.lap_en) begin
      lap_r <= LAP_W'(left_val) - (LAP_W'(center_val) <<< 1) + LAP_W'(right_val);
    end
    if (ctrl.mul_en) begin
      prod_r <= PROD_W'(lap_r) * $signed({1'b0, lambda});
    end
  end

  // round half up, then floor by the fraction width
  always_comb begin
    prod_rnd = prod_r + PROD_W'(1 << (FRAC_W - 1));
    delta    = SUM_W'(prod_rnd >>> FRAC_W);
    sum      = delta + SUM_W'(center_val);
    if (sum > SAT_HI) begin
      result = VAL_W'(SAT_HI);
    end else if (sum < SAT_LO) begin
      result = VAL_W'(SAT_LO);
    end else begin
      result = VAL_W'(sum);
    end
  end

endmodule

// ===== hw/rtl/heat_equation_ftcs_stepper_unit.sv =====
// Top level of the FTCS heat equation stepper: sequencer, row memory, output register.
// Depends on ftcs_pkg and ftcs_point_unit.
//
// Load requests (tuser 0) write one point of the row. A step request
// (tuser 1) walks the stored row from index 0 to the right boundary and emits
// one result per point, tlast on the boundary; the shared stencil unit takes
// each point through Laplacian, multiply, and round and saturate in turn, and
// an output stall holds the walk. in_tready is low for the whole step. Every
// row point read by a step must have been loaded first.
module heat_equation_ftcs_stepper_unit import ftcs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [71:0]         in_tdata,   // position[5:0], value_left[37:6], value_right[69:38]
  input  logic                in_tuser,   // command
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,  // position_res[5:0], value[37:6]
  output logic                out_tlast,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [LAMBDA_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [LAMBDA_W-1:0]      lambda_r;
  logic [LAST_W-1:0]        last_r;
  logic [ADDR_W-1:0]        eff_last;
  logic [ADDR_W-1:0]        idx_r, idx_nxt;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     wr_en;
  logic signed [VAL_W-1:0]  wr_data;
  logic signed [VAL_W-1:0]  mem [MAX_POINTS];
  logic signed [VAL_W-1:0]  rd_data_r;
  logic signed [VAL_W-1:0]  prev_r, cur_r, right_r;
  logic signed [VAL_W-1:0]  bnd_left_r, bnd_right_r;
  logic signed [VAL_W-1:0]  pu_result;
  logic signed [VAL_W-1:0]  point_val;
  pu_ctrl_t                 pu_ctrl;
  logic                     in_go, fin_go;
  logic [POS_W-1:0]         in_pos;
  logic                     out_valid_r;
  logic [POS_W-1:0]         out_pos_r;
  logic signed [VAL_W-1:0]  out_val_r;
  logic                     out_last_r;

  assign in_pos = in_tdata[POS_W-1:0];
  assign in_go  = in_tvalid && in_tready;
  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_r <= LAMBDA_RST;
      last_r   <= LAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LAMBDA: lambda_r <= (cfg_wdata > LAMBDA_MAX) ? LAMBDA_MAX : cfg_wdata;
        CFG_LAST:   last_r   <= cfg_wdata[LAST_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (last_r < LAST_MIN) begin
      eff_last = ADDR_W'(LAST_MIN);
    end else if (32'(last_r) > MAX_POINTS - 1) begin
      eff_last = ADDR_W'(MAX_POINTS - 1);
    end else begin
      eff_last = ADDR_W'(last_r);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    in_tready      = 1'b0;
    pu_ctrl.lap_en = 1'b0;
    pu_ctrl.mul_en = 1'b0;
    rd_addr        = ADDR_W'(idx_r + ADDR_W'(2));
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = point_val;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        rd_addr   = '0;
        if (in_go) begin
          if (in_tuser == CMD_STEP) begin
            idx_nxt   = '0;
            state_nxt = ST_LOAD0;
          end else if (32'(in_pos) < MAX_POINTS) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(in_pos);
            wr_data = in_tdata[POS_W +: VAL_W];
          end
        end
      end
      ST_LOAD0: begin
        rd_addr   = ADDR_W'(1);
        state_nxt = ST_LAP;
      end
      ST_LAP: begin
        pu_ctrl.lap_en = 1'b1;
        state_nxt      = ST_MUL;
      end
      ST_MUL: begin
        pu_ctrl.mul_en = 1'b1;
        state_nxt      = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) begin
          wr_en = 1'b1;
          if (idx_r == eff_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = ST_LAP;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // row memory; old value at idx+1 is read before idx is rewritten
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // sliding window over the old row
  always_ff @(posedge clk) begin
    if (in_go && in_tuser == CMD_STEP) begin
      bnd_left_r  <= in_tdata[POS_W +: VAL_W];
      bnd_right_r <= in_tdata[POS_W + VAL_W +: VAL_W];
    end
    if (state_r == ST_LOAD0) begin
      cur_r <= rd_data_r;
    end
    if (state_r == ST_LAP) begin
      right_r <= rd_data_r;
    end
    if (fin_go) begin
      prev_r <= cur_r;
      cur_r  <= right_r;
    end
  end

  ftcs_point_unit u_point (
    .clk        (clk),
    .ctrl       (pu_ctrl),
    .left_val   (prev_r),
    .center_val (cur_r),
    .right_val  (rd_data_r),
    .lambda     (lambda_r),
    .result     (pu_result)
  );

  always_comb begin
    if (idx_r == '0) begin
      point_val = bnd_left_r;
    end else if (idx_r == eff_last) begin
      point_val = bnd_right_r;
    end else begin
      point_val = pu_result;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_pos_r  <= POS_W'(idx_r);
      out_val_r  <= point_val;
      out_last_r <= (idx_r == eff_last);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_val_r, out_pos_r};
  assign out_tlast  = out_last_r;

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[POS_W-1:0] == POS_W'(eff_last))
    else $error("end of row flagged away from the right boundary");

  a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_STEP |=> state_r == ST_LOAD0)
    else $error("step request did not start the row walk");

  a_lambda_cap: assert property (@(posedge clk) disable iff (!rst_n)
    lambda_r <= LAMBDA_MAX)
    else $error("gain above one half");

  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> out_tvalid)
    else $error("finished point not presented");

endmodule
